[design/three_hall_clarke_angle_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three_hall_clarke_angle design; thca_fifo includes them.
// Each macro expands to one labeled concurrent assertion on aclk, held off
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef THREE_HALL_CLARKE_ANGLE_ASSERT_SVH
`define THREE_HALL_CLARKE_ANGLE_ASSERT_SVH

// Same-cycle implication.
`define THCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define THCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/thca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thca_pkg
// Constants, arctangent table and shared types for the Hall angle block.
// ----------------------------------------------------------------------------
package thca_pkg;

    // sqrt(3)/2 in Q1.15
    localparam int unsigned SQRT3_HALF_Q15 = 28378;

    // Angle accumulator: Q9.16 degrees, signed
    localparam int unsigned ZW        = 26;
    localparam int unsigned ATAN_W    = 22;
    localparam int unsigned TABLE_LEN = 24;
    localparam int unsigned FRAC_BITS = 16;

    localparam logic signed [ZW-1:0] Z_PLUS_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Z_MINUS_90 = -ZW'(90 * 65536);

    // Whole-degree limit of the electrical angle
    localparam logic [9:0] DEG_LIMIT = 10'd180;

    // Decoupling queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    // atan(2^-i) in Q9.16 degrees, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117305,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[design/thca_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thca_front
// Accepts sample sets, forms the scaled Clarke vector and folds it into the
// right half plane before handing it to the queue.
// ----------------------------------------------------------------------------
module thca_front
    import thca_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned XW          = SAMPLE_BITS + 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_BITS-1:0]        s_phase_a_sample,
    input  logic [SAMPLE_BITS-1:0]        s_phase_b_sample,
    input  logic [SAMPLE_BITS-1:0]        s_phase_c_sample,
    input  fifo_status_t                  fifo_status,
    output logic                          push,
    output logic signed [XW-1:0]          push_x,
    output logic signed [XW-1:0]          push_y,
    output logic signed [ZW-1:0]          push_z
);

    localparam int unsigned PW = SAMPLE_BITS + 17;
    localparam logic signed [16:0] K_SQRT3 = 17'(SQRT3_HALF_Q15);

    logic                 valid_reg, valid_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [XW-1:0] x_next, y_next;
    logic signed [XW-1:0] sa, sb, sc;
    logic signed [SAMPLE_BITS:0] bc;
    logic signed [PW-1:0] y_prod;
    logic                 accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !valid_reg || !fifo_status.full;
    assign push    = valid_reg && !fifo_status.full;

    always_comb begin
        sa     = $signed({{(XW-SAMPLE_BITS){1'b0}}, s_phase_a_sample});
        sb     = $signed({{(XW-SAMPLE_BITS){1'b0}}, s_phase_b_sample});
        sc     = $signed({{(XW-SAMPLE_BITS){1'b0}}, s_phase_c_sample});
        bc     = $signed({1'b0, s_phase_b_sample}) - $signed({1'b0, s_phase_c_sample});
        y_prod = PW'(bc) * PW'(K_SQRT3);
        x_next = ((sa <<< 1) - sb - sc) <<< 14;
        y_next = XW'(y_prod);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // Fold the left half plane by a quarter turn
    always_comb begin
        push_x = x_reg;
        push_y = y_reg;
        push_z = '0;
        if (x_reg < 0) begin
            if (y_reg >= 0) begin
                push_x = y_reg;
                push_y = -x_reg;
                push_z = Z_PLUS_90;
            end else begin
                push_x = -y_reg;
                push_y = x_reg;
                push_z = Z_MINUS_90;
            end
        end
    end

endmodule

[design/thca_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thca_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module thca_fifo
    import thca_pkg::*;
#(
    parameter int unsigned DW = 88
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] wr_data,
    input  logic          pop,
    output logic [DW-1:0] rd_data,
    output fifo_status_t  status
);

    `include "three_hall_clarke_angle_assert.svh"

    logic [DW-1:0]      mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rd_data      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `THCA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "queue overfilled")
    `THCA_ASSERT_NEXT(a_push_grows, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "push lost")
    `THCA_ASSERT_NEXT(a_pop_shrinks, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "pop lost")
    `THCA_ASSERT_NEXT(a_ptr_track, push || pop,
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[FIFO_AW-1:0], "pointers out of step")

endmodule

[design/thca_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thca_cordic
// Unrolled vectoring CORDIC, one register stage per iteration, followed by
// conversion to whole degrees and the result register.
// ----------------------------------------------------------------------------
module thca_cordic
    import thca_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16,
    parameter int unsigned XW           = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fifo_status_t         fifo_status,
    output logic                 pop,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [8:0]    m_electrical_degrees,
    output logic signed [7:0]    m_mechanical_degrees
);

    localparam int unsigned NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic                 en;
    logic                 vld_reg [NS+1];
    logic signed [XW-1:0] x_reg   [NS+1];
    logic signed [XW-1:0] y_reg   [NS+1];
    logic signed [ZW-1:0] z_reg   [NS+1];

    logic                 m_valid_reg;
    logic signed [8:0]    deg_reg, deg_next;
    logic signed [7:0]    mech_reg, mech_next;

    // Whole pipeline advances unless the result register is held
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !fifo_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= in_x;
            y_reg[0] <= in_y;
            z_reg[0] <= in_z;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic signed [XW-1:0] xs, ys;
        logic signed [XW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        logic signed [ZW-1:0] atan_k;

        assign atan_k = $signed(ZW'(ATAN_TABLE[k]));
        assign xs     = x_reg[k] >>> k;
        assign ys     = y_reg[k] >>> k;

        always_comb begin
            x_next = x_reg[k];
            y_next = y_reg[k];
            z_next = z_reg[k];
            if (y_reg[k] > 0) begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + atan_k;
            end else if (y_reg[k] < 0) begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - atan_k;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1] <= x_next;
                y_reg[k+1] <= y_next;
                z_reg[k+1] <= z_next;
            end
        end
    end

    // Truncate toward zero, clamp, halve toward zero
    always_comb begin
        logic            neg;
        logic [ZW-1:0]   zabs;
        logic [9:0]      whole;
        logic [8:0]      mag;
        logic [7:0]      half;
        neg   = z_reg[NS] < 0;
        zabs  = neg ? ZW'(-z_reg[NS]) : ZW'(z_reg[NS]);
        whole = zabs[FRAC_BITS+9:FRAC_BITS];
        mag   = (whole > DEG_LIMIT) ? DEG_LIMIT[8:0] : whole[8:0];
        half  = mag[8:1];
        deg_next  = neg ? -$signed(mag)               : $signed(mag);
        mech_next = neg ? -$signed(half)              : $signed(half);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg  <= deg_next;
            mech_reg <= mech_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_electrical_degrees = deg_reg;
    assign m_mechanical_degrees = mech_reg;

endmodule

[design/three_hall_clarke_angle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_hall_clarke_angle
// Rotor angle from three linear Hall samples: Clarke transform, then atan2
// by a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request carries three unsigned Hall samples.
//   Result channel m_*: one request per input, electrical angle in whole
//   degrees (-180..180) and mechanical angle (half of it, toward zero).
//   Both channels move a request when valid and ready are high together.
// Path: the front register loads at the accepting edge, then come the
//   queue, the CORDIC input register, one register per iteration (at most
//   24) and the result register.
// Throughput: one request per cycle while m_ready does not hold the pipeline;
//   the unrolled CORDIC pipeline and the front take a new request every clock.
// Stall: when m_ready is low with a result waiting, the CORDIC pipeline
//   holds; the front keeps accepting until the four-entry queue and its own
//   register are full, then drops s_ready.
// Reset: aresetn (synchronous, active low) clears all valid flags and the
//   queue; requests in flight are dropped, none is in flight after.
// ----------------------------------------------------------------------------
module three_hall_clarke_angle
    import thca_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16,
    parameter int unsigned SAMPLE_BITS  = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_phase_a_sample,
    input  logic [SAMPLE_BITS-1:0] s_phase_b_sample,
    input  logic [SAMPLE_BITS-1:0] s_phase_c_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [8:0]      m_electrical_degrees,
    output logic signed [7:0]      m_mechanical_degrees
);

    // Vector width: scaled Clarke terms plus room for the CORDIC gain
    localparam int unsigned XW = SAMPLE_BITS + 19;
    localparam int unsigned DW = 2 * XW + ZW;

    fifo_status_t         fifo_status;
    logic                 push, pop;
    logic signed [XW-1:0] push_x, push_y;
    logic signed [ZW-1:0] push_z;
    logic [DW-1:0]        rd_data;
    logic signed [XW-1:0] pop_x, pop_y;
    logic signed [ZW-1:0] pop_z;

    // Front: accept, form Clarke vector, fold into the right half plane
    thca_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .XW          (XW)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_phase_a_sample (s_phase_a_sample),
        .s_phase_b_sample (s_phase_b_sample),
        .s_phase_c_sample (s_phase_c_sample),
        .fifo_status      (fifo_status),
        .push             (push),
        .push_x           (push_x),
        .push_y           (push_y),
        .push_z           (push_z)
    );

    // Queue: decouple front and back stalls
    thca_fifo #(
        .DW (DW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data ({push_x, push_y, push_z}),
        .pop     (pop),
        .rd_data (rd_data),
        .status  (fifo_status)
    );

    assign pop_x = $signed(rd_data[DW-1 -: XW]);
    assign pop_y = $signed(rd_data[ZW+XW-1 -: XW]);
    assign pop_z = $signed(rd_data[ZW-1:0]);

    // Back: CORDIC iterations and degree conversion
    thca_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .XW           (XW)
    ) u_cordic (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .fifo_status          (fifo_status),
        .pop                  (pop),
        .in_x                 (pop_x),
        .in_y                 (pop_y),
        .in_z                 (pop_z),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_electrical_degrees (m_electrical_degrees),
        .m_mechanical_degrees (m_mechanical_degrees)
    );

endmodule

[bench/three_hall_clarke_angle_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_hall_clarke_angle_tb
// Self-checking bench for the Hall angle block. Feeds sets of three Hall
// samples through the s_ channel, predicts each rotor angle with an
// independent Clarke plus vectoring-CORDIC model and compares every m_
// result, field by field and in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module three_hall_clarke_angle_tb;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned SAMPLE_BITS  = 12;
    localparam int          RANDOM_SETS  = 850;
    // Worst case per request is the longest sender gap plus the longest
    // receiver stall plus the pipeline; take this several times over.
    localparam int          CYCLE_LIMIT  = 600000;
    // Drain for comfortably longer than a request spends in the pipeline.
    localparam int          DRAIN_CYCLES = 2 * (CORDIC_STEPS + 3) + 10;
    localparam longint      DEG_ONE      = 65536;
    localparam longint      SIN60_Q15    = 28378;
    localparam int          ATAN_LEN     = 24;

    // atan(2^-i) in Q9.16 degrees
    localparam longint ATAN_Q16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] phase_a;
        logic [SAMPLE_BITS-1:0] phase_b;
        logic [SAMPLE_BITS-1:0] phase_c;
    } hall_set_t;

    typedef struct packed {
        logic signed [8:0] electrical;
        logic signed [7:0] mechanical;
    } rotor_angle_t;

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_phase_a_sample = '0;
    logic [SAMPLE_BITS-1:0] s_phase_b_sample = '0;
    logic [SAMPLE_BITS-1:0] s_phase_c_sample = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic signed [8:0]      m_electrical_degrees;
    logic signed [7:0]      m_mechanical_degrees;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    hall_set_t    hall_sets_pending [$];  // requests not yet offered
    rotor_angle_t angles_due [$];         // predicted angles, oldest first
    int           sets_total      = 0;
    int           sets_taken      = 0;
    int           sets_sent       = 0;    // requests put on the s_ channel
    int           fault_count     = 0;
    int           cycle_count     = 0;
    int           send_gap        = 0;
    int           send_calm       = 0;
    int           stall_left      = 0;
    int           stall_calm      = 0;

    three_hall_clarke_angle #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_phase_a_sample    (s_phase_a_sample),
        .s_phase_b_sample    (s_phase_b_sample),
        .s_phase_c_sample    (s_phase_c_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_electrical_degrees(m_electrical_degrees),
        .m_mechanical_degrees(m_mechanical_degrees)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Angle predictor: Clarke components at a common 2^14 scale, then a
    // vectoring CORDIC that drives Y to zero and sums the turned angles.
    // ------------------------------------------------------------------------
    function automatic rotor_angle_t predict_rotor_angle(hall_set_t hs);
        longint       x;
        longint       y;
        longint       z;
        longint       t;
        longint       xs;
        longint       ys;
        longint       deg;
        longint       half;
        int           i;
        rotor_angle_t r;
        x = (2 * longint'(hs.phase_a) - longint'(hs.phase_b) - longint'(hs.phase_c)) * 16384;
        y = SIN60_Q15 * (longint'(hs.phase_b) - longint'(hs.phase_c));
        z = 0;
        // Left half plane: pre-rotate by a quarter turn toward the X axis
        if (x < 0) begin
            if (y >= 0) begin
                t = x;
                x = y;
                y = -t;
                z = 90 * DEG_ONE;
            end else begin
                t = x;
                x = -y;
                y = t;
                z = -90 * DEG_ONE;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            // >>> on a signed value floors, as the datapath shift does
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end
        end
        // Truncate toward zero to whole degrees, then clamp overshoot
        deg = (z >= 0) ? (z / DEG_ONE) : -((-z) / DEG_ONE);
        if (deg > 180) deg = 180;
        if (deg < -180) deg = -180;
        half = deg / 2;
        r.electrical = deg[8:0];
        r.mechanical = half[7:0];
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a calm
    // stretch with no idling at all.
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_set(int a, int b, int c);
        hall_set_t hs;
        hs.phase_a = clip_sample(a);
        hs.phase_b = clip_sample(b);
        hs.phase_c = clip_sample(c);
        hall_sets_pending.push_back(hs);
        sets_total++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer requests at the falling edge; hold the payload until the
    // rising edge that accepts it.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && (sets_taken < sets_sent)) begin
            // hold: request still waiting for s_ready
        end else begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (hall_sets_pending.size() > 0) begin
                s_phase_a_sample <= hall_sets_pending[0].phase_a;
                s_phase_b_sample <= hall_sets_pending[0].phase_b;
                s_phase_c_sample <= hall_sets_pending[0].phase_c;
                void'(hall_sets_pending.pop_front());
                s_valid <= 1'b1;
                sets_sent++;
                send_gap = pick_idle(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, also changed at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_idle(stall_calm);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge record the accepted request's predicted
    // angle and check any accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                angles_due.push_back(predict_rotor_angle(
                    '{s_phase_a_sample, s_phase_b_sample, s_phase_c_sample}));
                sets_taken++;
            end
            if (m_valid && m_ready) begin
                if (angles_due.size() == 0) begin
                    $display("%0t: result with none expected: elec %0d mech %0d",
                             $time, m_electrical_degrees, m_mechanical_degrees);
                    fault_count++;
                end else begin
                    if (m_electrical_degrees !== angles_due[0].electrical) begin
                        $display("%0t: electrical_degrees expected %0d actual %0d",
                                 $time, angles_due[0].electrical, m_electrical_degrees);
                        fault_count++;
                    end
                    if (m_mechanical_degrees !== angles_due[0].mechanical) begin
                        $display("%0t: mechanical_degrees expected %0d actual %0d",
                                 $time, angles_due[0].mechanical, m_mechanical_degrees);
                        fault_count++;
                    end
                    void'(angles_due.pop_front());
                end
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int k;
        int mode;
        int base;
        int b;
        int c;

        // Directed: field extremes, equal samples, axes and near-180 cases
        add_set(0, 0, 0);                 // equal samples at zero
        add_set(4095, 4095, 4095);        // equal samples at full scale
        add_set(2048, 2048, 2048);
        add_set(4095, 0, 0);              // pure +alpha
        add_set(0, 4095, 4095);           // pure -alpha, beta zero
        add_set(0, 4095, 0);              // left half, beta positive
        add_set(0, 0, 4095);              // left half, beta negative
        add_set(4095, 4095, 0);
        add_set(4095, 0, 4095);
        add_set(2048, 4095, 1);           // alpha zero, beta positive
        add_set(2048, 1, 4095);           // alpha zero, beta negative
        add_set(0, 4095, 4094);           // just above the negative axis
        add_set(0, 4094, 4095);           // just below the negative axis
        add_set(0, 2048, 2047);
        add_set(0, 2047, 2048);
        add_set(0, 1, 1);
        add_set(1, 0, 0);
        add_set(0, 1, 0);
        add_set(0, 0, 1);
        add_set(4094, 4095, 4093);
        add_set(12'hAAA, 12'h555, 12'hFFF);
        add_set(12'h555, 12'hAAA, 12'h000);
        add_set(4095, 0, 1);              // right half, beta just negative
        add_set(4095, 1, 0);

        // Random: full-range sets plus shapes that hit axes and small vectors
        for (k = 0; k < RANDOM_SETS; k++) begin
            mode = $urandom_range(0, 9);
            case (mode)
                4, 5: begin
                    // near-equal samples: tiny vectors in every direction
                    base = $urandom_range(0, 4095);
                    add_set(base + $urandom_range(0, 6) - 3,
                            base + $urandom_range(0, 6) - 3,
                            base + $urandom_range(0, 6) - 3);
                end
                6: begin
                    // beta near zero: angle near 0 or +-180
                    b = $urandom_range(0, 4095);
                    add_set($urandom_range(0, 4095), b, b + $urandom_range(0, 4) - 2);
                end
                7: begin
                    // alpha near zero: angle near +-90
                    b = $urandom_range(0, 4095);
                    c = $urandom_range(0, 4095);
                    add_set((b + c) / 2 + $urandom_range(0, 2) - 1, b, c);
                end
                8: begin
                    // one sample pinned at a rail
                    base = $urandom_range(0, 1) ? 4095 : 0;
                    case ($urandom_range(0, 2))
                        0: add_set(base, $urandom_range(0, 4095), $urandom_range(0, 4095));
                        1: add_set($urandom_range(0, 4095), base, $urandom_range(0, 4095));
                        default: add_set($urandom_range(0, 4095), $urandom_range(0, 4095), base);
                    endcase
                end
                9: begin
                    // small swing around mid-scale
                    add_set(2048 + $urandom_range(0, 100) - 50,
                            2048 + $urandom_range(0, 100) - 50,
                            2048 + $urandom_range(0, 100) - 50);
                end
                default: begin
                    add_set($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
                end
            endcase
        end

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken and every angle to come back
        while (sets_taken < sets_total) @(posedge aclk);
        while (angles_due.size() != 0) @(posedge aclk);
        // Let the pipeline run dry; a stray result here is flagged by the monitor
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
